// ----- rtl/core/dpvr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpvr_pkg
// Shared codes and masks for the dual-plane video RAM port.
// ----------------------------------------------------------------------------
`default_nettype none

package dpvr_pkg;

    typedef logic [2:0] t_func;

    localparam t_func FUNC_RAM_RD  = 3'd0;
    localparam t_func FUNC_RAM_WR  = 3'd1;
    localparam t_func FUNC_CTRL_RD = 3'd2;
    localparam t_func FUNC_CTRL_WR = 3'd3;
    localparam t_func FUNC_PIXEL   = 3'd4;

    localparam logic [15:0] PIXEL_MASK = 16'h7FFF;
    localparam int          BANK_BIT   = 11;

endpackage

`default_nettype wire

// ----- rtl/core/dual_plane_video_ram_port.sv -----
// ----------------------------------------------------------------------------
// dual_plane_video_ram_port
// Bus and pixel port onto a video store of 16-bit word pairs, with a bank bit
// choosing the low or high byte view of each pair.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | to block  | i_in_valid / o_in_stall   | func, pair_index, write_data,
//          |           |                           | pixel_row, pixel_column
//  out     | from block| o_out_valid / i_out_stall | read_data
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | palette fill word
//
//  One request per cycle sustained once cleared and while the output is not
//  stalled; a request passes the stage-one registers to the output register:
//  memory read at the accepting edge, then merge and write back. A write is
//  forwarded to a later request that reads the same pair.
//  After reset a clearing pass zeroes every pair of both planes, with
//  o_in_stall high throughout; cfg writes are taken during it.
//  A stalled output holds the pipeline; one request may wait behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_plane_video_ram_port #(
    parameter int PAIR_BITS = 18
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_data,

    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [2:0]  i_func,
    input  wire  [17:0] i_pair_index,
    input  wire  [15:0] i_write_data,
    input  wire  [8:0]  i_pixel_row,
    input  wire  [8:0]  i_pixel_column,

    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [15:0] o_read_data
);

    localparam int DEPTH = 1 << PAIR_BITS;
    localparam int WB    = PAIR_BITS + 1;

    logic [15:0] mem_even [DEPTH];
    logic [15:0] mem_odd  [DEPTH];

    logic [PAIR_BITS:0]   r_clr_cnt;
    logic                 clr_done;

    logic [15:0]          r_palette;
    logic [15:0]          r_control;
    logic                 r_bank;

    logic                 r_s1_vld;
    logic [2:0]           r_s1_func;
    logic [PAIR_BITS-1:0] r_s1_addr;
    logic [15:0]          r_s1_data;
    logic                 r_s1_odd;
    logic [15:0]          r_even_q;
    logic [15:0]          r_odd_q;

    logic                 r_fwd_vld;
    logic [PAIR_BITS-1:0] r_fwd_addr;
    logic [15:0]          r_fwd_even;
    logic [15:0]          r_fwd_odd;

    logic                 r_out_vld;
    logic [15:0]          r_out_data;

    logic                 accept;
    logic                 s1_adv;
    logic [17:0]          pix_word;
    logic [WB-1:0]        pix_idx;
    logic [PAIR_BITS-1:0] rd_addr;
    logic [15:0]          cur_even;
    logic [15:0]          cur_odd;
    logic [15:0]          n_even;
    logic [15:0]          n_odd;
    logic [15:0]          n_result;
    logic                 wr_pair;
    logic                 mem_we;
    logic [PAIR_BITS-1:0] mem_wa;
    logic [15:0]          mem_wd_even;
    logic [15:0]          mem_wd_odd;

    assign clr_done    = r_clr_cnt[PAIR_BITS];
    assign s1_adv      = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = !clr_done || (r_s1_vld && !s1_adv);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_read_data = r_out_data;

    assign pix_word = {i_pixel_row, i_pixel_column};
    assign pix_idx  = WB'({1'b0, pix_word});

    always_comb begin
        if (i_func == dpvr_pkg::FUNC_PIXEL) begin
            rd_addr = pix_idx[WB-1:1];
        end else begin
            rd_addr = i_pair_index[PAIR_BITS-1:0];
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_addr)) begin
            cur_even = r_fwd_even;
            cur_odd  = r_fwd_odd;
        end else begin
            cur_even = r_even_q;
            cur_odd  = r_odd_q;
        end
    end

    always_comb begin
        if (r_bank) begin
            n_even = {r_palette[7:0], r_s1_data[7:0]};
            n_odd  = {r_palette[15:8], r_s1_data[15:8]};
        end else begin
            n_even = {r_s1_data[7:0], cur_even[7:0]};
            n_odd  = {r_s1_data[15:8], cur_odd[7:0]};
        end
    end

    always_comb begin
        case (r_s1_func)
            dpvr_pkg::FUNC_RAM_RD: begin
                if (r_bank) begin
                    n_result = {cur_odd[7:0], cur_even[7:0]};
                end else begin
                    n_result = {cur_odd[15:8], cur_even[15:8]};
                end
            end
            dpvr_pkg::FUNC_CTRL_RD: begin
                n_result = r_control;
            end
            dpvr_pkg::FUNC_PIXEL: begin
                n_result = (r_s1_odd ? cur_odd : cur_even) & dpvr_pkg::PIXEL_MASK;
            end
            default: begin
                n_result = 16'h0000;
            end
        endcase
    end

    assign wr_pair = s1_adv && (r_s1_func == dpvr_pkg::FUNC_RAM_WR);

    always_comb begin
        if (!clr_done) begin
            mem_we      = 1'b1;
            mem_wa      = r_clr_cnt[PAIR_BITS-1:0];
            mem_wd_even = 16'h0000;
            mem_wd_odd  = 16'h0000;
        end else begin
            mem_we      = wr_pair;
            mem_wa      = r_s1_addr;
            mem_wd_even = n_even;
            mem_wd_odd  = n_odd;
        end
    end

    // planes: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_even[mem_wa] <= mem_wd_even;
            mem_odd[mem_wa]  <= mem_wd_odd;
        end
        if (accept) begin
            r_even_q <= mem_even[rd_addr];
            r_odd_q  <= mem_odd[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_palette <= 16'h0000;
            r_control <= 16'h0000;
            r_bank    <= 1'b1;
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!clr_done) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_valid) begin
                r_palette <= i_cfg_data;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv && (r_s1_func == dpvr_pkg::FUNC_CTRL_WR)) begin
                r_control <= r_s1_data;
                r_bank    <= r_s1_data[dpvr_pkg::BANK_BIT];
            end
            if (wr_pair) begin
                r_fwd_vld <= 1'b1;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_func <= i_func;
            r_s1_addr <= rd_addr;
            r_s1_data <= i_write_data;
            r_s1_odd  <= pix_idx[0];
        end
        if (wr_pair) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_even <= n_even;
            r_fwd_odd  <= n_odd;
        end
        if (s1_adv) begin
            r_out_data <= n_result;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dpvr_checker.sv -----
// ----------------------------------------------------------------------------
// dpvr_checker
// Port-level checks on the dual-plane video RAM port, bound into the port module.
// ----------------------------------------------------------------------------
`default_nettype none

module dpvr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [15:0] o_read_data
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("stalled result changed");

    // a fresh result follows its taken request through stage one and the output register
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without request");

    // one request may wait behind a stalled result, no more
    a_backpress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_in_valid && !o_in_stall) && o_out_valid && i_out_stall |-> o_in_stall)
        else $error("request taken with pipeline full");

endmodule

bind dual_plane_video_ram_port dpvr_checker u_dpvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_data (o_read_data)
);

`default_nettype wire

// ----- dv/dual_plane_video_ram_port_tb.sv -----
// ----------------------------------------------------------------------------
// dual_plane_video_ram_port_tb
// Self-checking bench for the dual-plane video RAM port. A queue-fed driver
// sends bus and pixel requests with random gaps, the output is stalled at
// random, and every result is checked against a cycle-free model of both
// planes, the control word, the bank bit and the palette fill word. The
// palette word is changed between phases while the port is idle.
// ----------------------------------------------------------------------------
module dual_plane_video_ram_port_tb;

    localparam int              PAIR_BITS     = 18;
    localparam int              PAIR_COUNT    = 1 << PAIR_BITS;
    localparam int              PHASES        = 6;
    localparam int              PHASE_REQS    = 250;
    localparam dpvr_pkg::t_func FUNC_SPARE_LO = 3'd5;
    localparam dpvr_pkg::t_func FUNC_SPARE_HI = 3'd7;

    typedef struct {
        dpvr_pkg::t_func func;
        logic [17:0]     pair;
        logic [15:0]     wdata;
        logic [8:0]      row;
        logic [8:0]      col;
        bit              drain_first;
    } t_video_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_func;
    logic [17:0] i_pair_index;
    logic [15:0] i_write_data;
    logic [8:0]  i_pixel_row;
    logic [8:0]  i_pixel_column;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_read_data;

    // model state
    logic [15:0] even_plane [0:PAIR_COUNT-1];
    logic [15:0] odd_plane  [0:PAIR_COUNT-1];
    logic [15:0] ctrl_word;
    logic        bank_sel;
    logic [15:0] palette_word;

    t_video_req  pending_reqs [$];
    logic [15:0] expected_reads [$];
    logic [17:0] hot_pairs [$];
    t_video_req  cur_req;
    logic        req_taken;
    int          error_count;
    int          send_gap;
    int          send_calm;
    int          stall_left;
    int          recv_calm;

    dual_plane_video_ram_port #(
        .PAIR_BITS(PAIR_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_pair_index  (i_pair_index),
        .i_write_data  (i_write_data),
        .i_pixel_row   (i_pixel_row),
        .i_pixel_column(i_pixel_column),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] predict_read_data(t_video_req r);
        logic [PAIR_BITS-1:0] p;
        logic [PAIR_BITS:0]   w;
        logic [15:0]          e;
        logic [15:0]          o;
        logic [15:0]          res;
        p   = r.pair[PAIR_BITS-1:0];
        e   = even_plane[p];
        o   = odd_plane[p];
        res = '0;
        case (r.func)
            dpvr_pkg::FUNC_RAM_RD: begin
                res = bank_sel ? {o[7:0], e[7:0]} : {o[15:8], e[15:8]};
            end
            dpvr_pkg::FUNC_RAM_WR: begin
                if (bank_sel) begin
                    even_plane[p] = {palette_word[7:0], r.wdata[7:0]};
                    odd_plane[p]  = {palette_word[15:8], r.wdata[15:8]};
                end else begin
                    even_plane[p] = {r.wdata[7:0], e[7:0]};
                    odd_plane[p]  = {r.wdata[15:8], o[7:0]};
                end
            end
            dpvr_pkg::FUNC_CTRL_RD: begin
                res = ctrl_word;
            end
            dpvr_pkg::FUNC_CTRL_WR: begin
                ctrl_word = r.wdata;
                bank_sel  = r.wdata[dpvr_pkg::BANK_BIT];
            end
            dpvr_pkg::FUNC_PIXEL: begin
                w   = (PAIR_BITS+1)'({1'b0, r.row, r.col});
                res = (w[0] ? odd_plane[w[PAIR_BITS:1]] : even_plane[w[PAIR_BITS:1]])
                      & dpvr_pkg::PIXEL_MASK;
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_video_req random_req();
        t_video_req  r;
        int          sel;
        logic [18:0] w;
        r.wdata       = 16'($urandom);
        r.row         = 9'($urandom);
        r.col         = 9'($urandom);
        r.drain_first = 1'b0;
        sel = $urandom_range(0, 9);
        if (sel < 4 && hot_pairs.size() != 0)
            r.pair = hot_pairs[$urandom_range(0, hot_pairs.size() - 1)];
        else if (sel < 7)
            r.pair = 18'($urandom_range(0, 63));
        else
            r.pair = 18'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 25)      r.func = dpvr_pkg::FUNC_RAM_RD;
        else if (sel < 55) r.func = dpvr_pkg::FUNC_RAM_WR;
        else if (sel < 63) r.func = dpvr_pkg::FUNC_CTRL_RD;
        else if (sel < 71) r.func = dpvr_pkg::FUNC_CTRL_WR;
        else if (sel < 94) r.func = dpvr_pkg::FUNC_PIXEL;
        else r.func = dpvr_pkg::t_func'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        if (r.func == dpvr_pkg::FUNC_RAM_WR) begin
            hot_pairs.push_back(r.pair);
            if (hot_pairs.size() > 32) void'(hot_pairs.pop_front());
        end
        // aim most fetches at the pair chosen for this request
        if (r.func == dpvr_pkg::FUNC_PIXEL && $urandom_range(0, 3) != 0) begin
            w = {r.pair, 1'($urandom_range(0, 1))};
            if (w <= 19'h3FFFF) begin
                r.row = w[17:9];
                r.col = w[8:0];
            end
        end
        return r;
    endfunction

    task automatic push_req(dpvr_pkg::t_func f, logic [17:0] pair, logic [15:0] d,
                            logic [8:0] row, logic [8:0] col);
        t_video_req r;
        r.func        = f;
        r.pair        = pair;
        r.wdata       = d;
        r.row         = row;
        r.col         = col;
        r.drain_first = 1'b0;
        pending_reqs.push_back(r);
    endtask

    task automatic write_palette(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        palette_word = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_reads.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_video_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && expected_reads.size() != 0)) begin
                nxt = pending_reqs.pop_front();
                cur_req = nxt;
                i_func         <= nxt.func;
                i_pair_index   <= nxt.pair;
                i_write_data   <= nxt.wdata;
                i_pixel_row    <= nxt.row;
                i_pixel_column <= nxt.col;
                i_in_valid     <= 1'b1;
                if (send_calm > 0) begin
                    send_calm--;
                end else begin
                    if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(50, 200);
                    send_gap = pick_gap();
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(negedge i_clk) begin
        if (recv_calm > 0) begin
            recv_calm--;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            if ($urandom_range(0, 199) == 0) recv_calm = $urandom_range(50, 200);
            stall_left = pick_gap();
            i_out_stall <= 1'b0;
        end
    end

    // request acceptance and prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                expected_reads.push_back(predict_read_data(cur_req));
        end
    end

    // result check
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reads.size() == 0) begin
                $error("read_data: unexpected result %h", o_read_data);
                error_count++;
            end else begin
                want = expected_reads.pop_front();
                if (o_read_data !== want) begin
                    $error("read_data: expected %h, actual %h", want, o_read_data);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [15:0] phase_palette [PHASES];
        int          drain_at;
        t_video_req  r;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_func         = dpvr_pkg::FUNC_RAM_RD;
        i_pair_index   = '0;
        i_write_data   = '0;
        i_pixel_row    = '0;
        i_pixel_column = '0;
        i_out_stall    = 1'b0;
        error_count    = 0;
        send_gap       = 0;
        send_calm      = 0;
        stall_left     = 0;
        recv_calm      = 0;
        ctrl_word      = '0;
        bank_sel       = 1'b1;
        palette_word   = '0;
        for (int i = 0; i < PAIR_COUNT; i++) begin
            even_plane[i] = '0;
            odd_plane[i]  = '0;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_palette(16'hA5C3);
        push_req(dpvr_pkg::FUNC_RAM_WR,  18'h00000, 16'h3C5A, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_RD,  18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_WR,  18'h3FFFF, 16'hFFFF, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_RD,  18'h3FFFF, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_PIXEL,   18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_PIXEL,   18'h00000, 16'h0000, 9'd0,   9'd1);
        push_req(dpvr_pkg::FUNC_PIXEL,   18'h00000, 16'h0000, 9'd511, 9'd511);
        push_req(dpvr_pkg::FUNC_CTRL_RD, 18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_CTRL_WR, 18'h00000, 16'hFFFF, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_CTRL_RD, 18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_RD,  18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_WR,  18'h00000, 16'hA55A, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_RD,  18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_RD,  18'h3FFFF, 16'h0000, 9'd0,   9'd0);
        for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++)
            push_req(dpvr_pkg::t_func'(f), 18'h00000, 16'hFFFF, 9'd511, 9'd511);
        push_req(dpvr_pkg::FUNC_RAM_RD,  18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_CTRL_WR, 18'h00000, 16'hF7FF, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_CTRL_RD, 18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_CTRL_WR, 18'h00000, 16'h0800, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_RD,  18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_PIXEL,   18'h00000, 16'h0000, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_RAM_WR,  18'h00001, 16'h8001, 9'd0,   9'd0);
        push_req(dpvr_pkg::FUNC_PIXEL,   18'h00000, 16'h0000, 9'd0,   9'd3);
        wait_idle();

        phase_palette[0] = 16'hFFFF;
        phase_palette[1] = 16'h0000;
        phase_palette[2] = 16'($urandom);
        phase_palette[3] = 16'h00FF;
        phase_palette[4] = 16'hFF00;
        phase_palette[5] = 16'($urandom);
        for (int ph = 0; ph < PHASES; ph++) begin
            write_palette(phase_palette[ph]);
            drain_at = $urandom_range(20, PHASE_REQS - 20);
            for (int n = 0; n < PHASE_REQS; n++) begin
                r = random_req();
                r.drain_first = (n == drain_at);
                pending_reqs.push_back(r);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dpvr_pkg.sv
rtl/core/dual_plane_video_ram_port.sv
rtl/core/dpvr_checker.sv
dv/dual_plane_video_ram_port_tb.sv
